// ===== sv/fcm_pkg.sv =====
// shared types and constants for the flow cache meter
package fcm_pkg;

    localparam int unsigned DEF_CACHE_DEPTH = 64;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [31:0] RST_ACTIVE_MS = 32'd60000;
    localparam logic [31:0] RST_INACTIVE_MS = 32'd10000;
    localparam logic [5:0] RST_MAX_FLOWS = 6'd63;
    localparam int unsigned FLAG_FIN = 0;
    localparam int unsigned FLAG_RST = 2;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_INACTIVE = 2'd1;
    localparam logic [1:0] REG_MAX_FLOWS = 2'd2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [7:0]  tos;
        logic [7:0]  flags;
        logic [31:0] pkts;
        logic [31:0] octets;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
    } fcm_entry_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } fcm_cell_ctl_t;

endpackage

// ===== sv/fcm_cell.sv =====
// one flow slot of the cache chain
module fcm_cell #(
    parameter int unsigned IDX_W = 6,
    parameter int unsigned IDX = 0
) (
    input  logic                 clk,
    input  fcm_pkg::fcm_cell_ctl_t ctl,
    input  logic [IDX_W-1:0]     wr_idx,
    input  fcm_pkg::fcm_entry_t  wr_entry,
    input  fcm_pkg::fcm_entry_t  right_entry,
    output fcm_pkg::fcm_entry_t  entry
);
    import fcm_pkg::*;

    fcm_entry_t entry_reg;

    // a write to this slot wins over the shift from the neighbor
    always_ff @(posedge clk)
    begin
        if (ctl.wr && wr_idx == IDX_W'(IDX))
        begin
            entry_reg <= wr_entry;
        end
        else if (ctl.shift)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== sv/flow_cache_meter_top.sv =====
// flow cache meter top level: config port, walk control and cell chain
// An item (one packet) is taken when start is high and busy is low. The cache is a chain of
// slots kept oldest first; the packet walks it one flow per cycle through a single compare and
// update unit at the head, and a new item is taken only once the walk, insert, trim and flush
// steps are done. Exported flows appear one per cycle at most, each for a single cycle with
// valid high; the receiver cannot stall, and last_of_run marks the final export of an item.
module flow_cache_meter_top #(
    parameter int unsigned CACHE_DEPTH = fcm_pkg::DEF_CACHE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  protocol,
    input  logic [7:0]  tos,
    input  logic [15:0] ip_length,
    input  logic [7:0]  pkt_flags,
    input  logic [31:0] uptime_ms,
    output logic        valid,
    output logic [31:0] exp_src_addr,
    output logic [31:0] exp_dst_addr,
    output logic [15:0] exp_src_port,
    output logic [15:0] exp_dst_port,
    output logic [7:0]  exp_protocol,
    output logic [7:0]  exp_tos,
    output logic [7:0]  exp_flags,
    output logic [31:0] packet_count,
    output logic [31:0] octet_count,
    output logic [31:0] first_seen_ms,
    output logic [31:0] last_seen_ms,
    output logic        last_of_run
);
    import fcm_pkg::*;

    localparam int unsigned IDX_W = $clog2(CACHE_DEPTH);
    localparam int unsigned LEN_W = $clog2(CACHE_DEPTH + 1);
    localparam int unsigned LIM_W = (LEN_W > 6) ? LEN_W : 6;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_INSERT = 3'd2;
    localparam logic [2:0] ST_TRIM = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [31:0] active_reg;
    logic [31:0] inactive_reg;
    logic [5:0]  max_flows_reg;

    logic [2:0]       state_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] rem_reg;
    logic             matched_reg;
    fcm_entry_t       pkt_reg;
    fcm_entry_t       pend_reg;
    logic             pend_vld_reg;
    fcm_entry_t       out_reg;
    logic             out_vld_reg;
    logic             out_last_reg;

    fcm_cell_ctl_t    ctl;
    logic [IDX_W-1:0] wr_idx;
    fcm_entry_t       wr_entry;
    fcm_entry_t       cell_q [CACHE_DEPTH];

    fcm_entry_t       head;
    fcm_entry_t       upd;
    fcm_entry_t       pkt_in;
    logic             live;
    logic             hit;
    logic             instant;
    logic signed [32:0] age_d;
    logic signed [32:0] idle_d;
    logic [LIM_W-1:0] limit;
    logic             do_emit;
    fcm_entry_t       emit_entry;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= RST_ACTIVE_MS;
            inactive_reg <= RST_INACTIVE_MS;
            max_flows_reg <= RST_MAX_FLOWS;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_ACTIVE:    active_reg <= pwdata;
                REG_INACTIVE:  inactive_reg <= pwdata;
                REG_MAX_FLOWS: max_flows_reg <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ACTIVE:    prdata = active_reg;
            REG_INACTIVE:  prdata = inactive_reg;
            REG_MAX_FLOWS: prdata = {26'd0, max_flows_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // packet as stored: ports cleared for icmp, flags only for tcp
    always_comb
    begin
        pkt_in.src_addr = src_addr;
        pkt_in.dst_addr = dst_addr;
        pkt_in.src_port = (protocol == PROTO_ICMP) ? 16'd0 : src_port;
        pkt_in.dst_port = (protocol == PROTO_ICMP) ? 16'd0 : dst_port;
        pkt_in.protocol = protocol;
        pkt_in.tos = tos;
        pkt_in.flags = (protocol == PROTO_TCP) ? pkt_flags : 8'd0;
        pkt_in.pkts = 32'd1;
        pkt_in.octets = {16'd0, ip_length};
        pkt_in.first_ms = uptime_ms;
        pkt_in.last_ms = uptime_ms;
    end

    assign head = cell_q[0];
    assign instant = pkt_reg.flags[FLAG_FIN] | pkt_reg.flags[FLAG_RST];

    // signed age checks, time running back keeps a flow live
    always_comb
    begin
        age_d = $signed({1'b0, pkt_reg.last_ms}) - $signed({1'b0, head.first_ms});
        idle_d = $signed({1'b0, pkt_reg.last_ms}) - $signed({1'b0, head.last_ms});
        live = (age_d < $signed({1'b0, active_reg})) && (idle_d < $signed({1'b0, inactive_reg}));
        hit = head.src_addr == pkt_reg.src_addr && head.dst_addr == pkt_reg.dst_addr
            && head.src_port == pkt_reg.src_port && head.dst_port == pkt_reg.dst_port
            && head.protocol == pkt_reg.protocol && head.tos == pkt_reg.tos;
        upd = head;
        upd.pkts = head.pkts + 32'd1;
        upd.octets = head.octets + pkt_reg.octets;
        upd.last_ms = pkt_reg.last_ms;
        upd.flags = head.flags | pkt_reg.flags;
        limit = (LIM_W'(max_flows_reg) > LIM_W'(CACHE_DEPTH - 1))
            ? LIM_W'(CACHE_DEPTH - 1) : LIM_W'(max_flows_reg);
    end

    // chain control and export selection
    always_comb
    begin
        ctl = '0;
        wr_idx = '0;
        wr_entry = upd;
        do_emit = 1'b0;
        emit_entry = head;
        unique case (state_reg)
            ST_WALK:
            begin
                ctl.shift = 1'b1;
                if (!live)
                begin
                    do_emit = 1'b1;
                end
                else if (hit && instant)
                begin
                    do_emit = 1'b1;
                    emit_entry = upd;
                end
                else
                begin
                    ctl.wr = 1'b1;
                    wr_idx = len_reg[IDX_W-1:0] - IDX_W'(1);
                    wr_entry = hit ? upd : head;
                end
            end
            ST_INSERT:
            begin
                if (!matched_reg && len_reg < LEN_W'(CACHE_DEPTH))
                begin
                    if (instant)
                    begin
                        do_emit = 1'b1;
                        emit_entry = pkt_reg;
                    end
                    else
                    begin
                        ctl.wr = 1'b1;
                        wr_idx = len_reg[IDX_W-1:0];
                        wr_entry = pkt_reg;
                    end
                end
            end
            ST_TRIM:
            begin
                if (LIM_W'(len_reg) > limit)
                begin
                    ctl.shift = 1'b1;
                    do_emit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg <= '0;
            rem_reg <= '0;
            matched_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            // exports go through a one-deep hold so the last one can be marked
            if (do_emit && pend_vld_reg)
            begin
                out_reg <= pend_reg;
                out_vld_reg <= 1'b1;
                out_last_reg <= 1'b0;
            end
            else if (state_reg == ST_FLUSH && pend_vld_reg)
            begin
                out_reg <= pend_reg;
                out_vld_reg <= 1'b1;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b0;
                out_last_reg <= 1'b0;
            end
            if (do_emit)
            begin
                pend_reg <= emit_entry;
                pend_vld_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        pkt_reg <= pkt_in;
                        rem_reg <= len_reg;
                        matched_reg <= 1'b0;
                        state_reg <= (len_reg == '0) ? ST_INSERT : ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (live && hit)
                    begin
                        matched_reg <= 1'b1;
                    end
                    if (!live || (hit && instant))
                    begin
                        len_reg <= len_reg - LEN_W'(1);
                    end
                    rem_reg <= rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                    begin
                        state_reg <= ST_INSERT;
                    end
                end
                ST_INSERT:
                begin
                    if (ctl.wr)
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                    state_reg <= ST_TRIM;
                end
                ST_TRIM:
                begin
                    if (ctl.shift)
                    begin
                        len_reg <= len_reg - LEN_W'(1);
                    end
                    state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    pend_vld_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_DEPTH; gi++)
        begin : g_cell
            fcm_entry_t right;
            if (gi == CACHE_DEPTH - 1)
            begin : g_end
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = cell_q[gi+1];
            end
            fcm_cell #(
                .IDX_W(IDX_W),
                .IDX(gi)
            ) u_cell (
                .clk(clk),
                .ctl(ctl),
                .wr_idx(wr_idx),
                .wr_entry(wr_entry),
                .right_entry(right),
                .entry(cell_q[gi])
            );
        end
    endgenerate

    assign busy = (state_reg != ST_IDLE);
    assign valid = out_vld_reg;
    assign last_of_run = out_last_reg;
    assign exp_src_addr = out_reg.src_addr;
    assign exp_dst_addr = out_reg.dst_addr;
    assign exp_src_port = out_reg.src_port;
    assign exp_dst_port = out_reg.dst_port;
    assign exp_protocol = out_reg.protocol;
    assign exp_tos = out_reg.tos;
    assign exp_flags = out_reg.flags;
    assign packet_count = out_reg.pkts;
    assign octet_count = out_reg.octets;
    assign first_seen_ms = out_reg.first_ms;
    assign last_seen_ms = out_reg.last_ms;

endmodule

// ===== sv/fcm_checker.sv =====
// port level checks for the flow cache meter, bound to the top level
module fcm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic valid,
    input logic last_of_run
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_of_run |=> !valid)
        else $error("export right after the last of a run");

    a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("export without an item in progress");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_of_run |-> !busy)
        else $error("last export while still busy");

endmodule

bind flow_cache_meter_top fcm_checker u_fcm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .valid(valid),
    .last_of_run(last_of_run)
);
